/* rtl/core/afc_pkg.sv */
`default_nettype none

package afc_pkg;

  localparam int NUM_CELLS = 6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  // matrix row that every plane adds or subtracts from
  localparam logic [1:0] ROW_W = 2'd3;

  typedef struct packed {
    logic valid;
    logic is_test;
    logic in_view;
  } ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/afc_cell.sv */
`default_nettype none

module afc_cell #(
  parameter int          COORD_BITS = 32,
  parameter int          FRAC_BITS  = 16,
  parameter int unsigned AXIS       = 0,
  parameter bit          NEG        = 1'b0
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire  afc_pkg::ctrl_t           in_ctrl,
  input  wire  [3:0]                     in_index,
  input  wire  [COORD_BITS-1:0]          in_value,
  input  wire  [2:0][COORD_BITS-1:0]     in_min,
  input  wire  [2:0][COORD_BITS-1:0]     in_max,
  output logic                           in_ready,
  output afc_pkg::ctrl_t                 out_ctrl,
  output logic [3:0]                     out_index,
  output logic [COORD_BITS-1:0]          out_value,
  output logic [2:0][COORD_BITS-1:0]     out_min,
  output logic [2:0][COORD_BITS-1:0]     out_max,
  input  wire                            out_ready
);

  localparam int PL_W    = COORD_BITS + 1;
  localparam int LO_BITS = COORD_BITS / 2;
  localparam int HI_BITS = COORD_BITS - LO_BITS;
  localparam int PPL_W   = PL_W + LO_BITS + 1;
  localparam int PPH_W   = PL_W + HI_BITS;
  localparam int SUM_W   = 2 * COORD_BITS + 3;

  // plane state: matrix row 3 and row AXIS, one entry per column
  logic [3:0][COORD_BITS-1:0] m_row3, m_row3_next;
  logic [3:0][COORD_BITS-1:0] m_axis, m_axis_next;
  logic [3:0][PL_W-1:0]       pl, pl_next;
  logic                       nz, nz_next;

  afc_pkg::ctrl_t             ctrl1, ctrl2, ctrl3;
  logic [3:0]                 idx1, idx2, idx3;
  logic [COORD_BITS-1:0]      val1, val2, val3;
  logic [2:0][COORD_BITS-1:0] min1, min2, min3;
  logic [2:0][COORD_BITS-1:0] max1, max2, max3;

  logic [2:0][PPL_W-1:0]      pp_lo1;
  logic [2:0][PPH_W-1:0]      pp_hi1;
  logic [PL_W-1:0]            w1;
  logic                       nz1;

  logic [2:0][SUM_W-1:0]      prod2;
  logic [SUM_W-1:0]           wsh2;
  logic                       nz2;

  logic                       rdy1, rdy2, rdy3;
  logic                       load1;

  logic [2:0][PPL_W-1:0]      pp_lo_c;
  logic [2:0][PPH_W-1:0]      pp_hi_c;
  logic [2:0][SUM_W-1:0]      prod_c;
  logic [SUM_W-1:0]           wsh_c;
  logic signed [SUM_W-1:0]    sum_c;
  logic                       cull_c;

  assign rdy3     = !ctrl3.valid || out_ready;
  assign rdy2     = !ctrl2.valid || rdy3;
  assign rdy1     = !ctrl1.valid || rdy2;
  assign in_ready = rdy1;
  assign load1    = rdy1 && in_ctrl.valid;

  // plane update as write items pass through
  always_comb begin
    m_row3_next = m_row3;
    m_axis_next = m_axis;
    if (load1 && in_ctrl.is_test == afc_pkg::OP_WRITE) begin
      if (in_index[1:0] == afc_pkg::ROW_W) begin
        m_row3_next[in_index[3:2]] = in_value;
      end
      if (in_index[1:0] == 2'(AXIS)) begin
        m_axis_next[in_index[3:2]] = in_value;
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (NEG) begin
        pl_next[c] = PL_W'($signed(m_row3_next[c])) - PL_W'($signed(m_axis_next[c]));
      end else begin
        pl_next[c] = PL_W'($signed(m_row3_next[c])) + PL_W'($signed(m_axis_next[c]));
      end
    end
    nz_next = (pl_next[0] != '0) || (pl_next[1] != '0) || (pl_next[2] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_row3 <= '0;
      m_axis <= '0;
      pl     <= '0;
      nz     <= 1'b0;
    end else begin
      m_row3 <= m_row3_next;
      m_axis <= m_axis_next;
      pl     <= pl_next;
      nz     <= nz_next;
    end
  end

  // stage 1: positive vertex and split partial products
  always_comb begin
    logic [COORD_BITS-1:0]     vtx;
    logic signed [LO_BITS:0]   lo_op;
    logic signed [HI_BITS-1:0] hi_op;
    for (int c = 0; c < 3; c++) begin
      vtx        = pl[c][PL_W-1] ? in_min[c] : in_max[c];
      lo_op      = $signed({1'b0, vtx[LO_BITS-1:0]});
      hi_op      = $signed(vtx[COORD_BITS-1:LO_BITS]);
      pp_lo_c[c] = PPL_W'($signed(pl[c]) * lo_op);
      pp_hi_c[c] = PPH_W'($signed(pl[c]) * hi_op);
    end
  end

  // stage 2: recombine products, align w
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_c[c] = (SUM_W'($signed(pp_hi1[c])) <<< LO_BITS) + SUM_W'($signed(pp_lo1[c]));
    end
    wsh_c = SUM_W'($signed(w1)) <<< FRAC_BITS;
  end

  // stage 3: plane distance sign
  assign sum_c  = $signed(wsh2) + $signed(prod2[0]) + $signed(prod2[1]) + $signed(prod2[2]);
  assign cull_c = nz2 && sum_c[SUM_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
      ctrl2 <= '0;
      ctrl3 <= '0;
    end else begin
      if (rdy1) begin
        ctrl1 <= in_ctrl;
      end
      if (rdy2) begin
        ctrl2 <= ctrl1;
      end
      if (rdy3) begin
        ctrl3.valid   <= ctrl2.valid;
        ctrl3.is_test <= ctrl2.is_test;
        ctrl3.in_view <= ctrl2.in_view && !cull_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      idx1   <= in_index;
      val1   <= in_value;
      min1   <= in_min;
      max1   <= in_max;
      pp_lo1 <= pp_lo_c;
      pp_hi1 <= pp_hi_c;
      w1     <= pl[3];
      nz1    <= nz;
    end
    if (rdy2 && ctrl1.valid) begin
      idx2  <= idx1;
      val2  <= val1;
      min2  <= min1;
      max2  <= max1;
      prod2 <= prod_c;
      wsh2  <= wsh_c;
      nz2   <= nz1;
    end
    if (rdy3 && ctrl2.valid) begin
      idx3 <= idx2;
      val3 <= val2;
      min3 <= min2;
      max3 <= max2;
    end
  end

  assign out_ctrl  = ctrl3;
  assign out_index = idx3;
  assign out_value = val3;
  assign out_min   = min3;
  assign out_max   = max3;

  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    (load1 && in_ctrl.is_test == afc_pkg::OP_WRITE && in_index[1:0] == afc_pkg::ROW_W)
    |=> m_row3[$past(in_index[3:2])] == $past(in_value))
    else $error("row 3 write did not land in cell");

  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
    nz == ((pl[0] != '0) || (pl[1] != '0) || (pl[2] != '0)))
    else $error("zero-normal flag out of step with plane");

  a_cull_sticky: assert property (@(posedge clk) disable iff (rst)
    (rdy3 && ctrl2.valid && !ctrl2.in_view) |=> !ctrl3.in_view)
    else $error("culled item came back inside");

endmodule

`default_nettype wire

/* rtl/core/aabb_frustum_cull_top.sv */
// aabb_frustum_cull_top
// Input channel (item_valid / item_stall): op 0 writes one view-projection
// matrix entry (entry_index = column * 4 + row, signed fixed point), op 1
// tests one box given by its min and max corners.
// Output channel (result_valid / result_stall): one inside_res per test item,
// 1 when the box is not behind any of the six frustum planes. Write items
// give no result.
// Items pass through a row of six plane cells, three register stages each,
// then an output register before a test result is shown. One item is taken
// per cycle while item_stall is low, writes and tests mixed freely; a
// write affects every test accepted after it and none before it.
// Reset clears the matrix to zero (every box then tests inside) and empties
// the cells. When the receiver stalls, items keep entering until the cells
// fill up; then item_stall rises in the same cycle.
`default_nettype none

module aabb_frustum_cull_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_stall,
  input  wire                   op,
  input  wire  [3:0]            entry_index,
  input  wire  [COORD_BITS-1:0] entry_value,
  input  wire  [COORD_BITS-1:0] box_min_x,
  input  wire  [COORD_BITS-1:0] box_min_y,
  input  wire  [COORD_BITS-1:0] box_min_z,
  input  wire  [COORD_BITS-1:0] box_max_x,
  input  wire  [COORD_BITS-1:0] box_max_y,
  input  wire  [COORD_BITS-1:0] box_max_z,
  output logic                  result_valid,
  input  wire                   result_stall,
  output logic                  inside_res
);

  localparam int N = afc_pkg::NUM_CELLS;

  afc_pkg::ctrl_t             chain_ctrl  [0:N];
  logic                       chain_ready [0:N];
  logic [3:0]                 chain_index [0:N-1];
  logic [COORD_BITS-1:0]      chain_value [0:N-1];
  logic [2:0][COORD_BITS-1:0] chain_min   [0:N-1];
  logic [2:0][COORD_BITS-1:0] chain_max   [0:N-1];
  afc_pkg::ctrl_t             last_ctrl;

  assign chain_ctrl[0].valid   = item_valid;
  assign chain_ctrl[0].is_test = (op == afc_pkg::OP_TEST);
  assign chain_ctrl[0].in_view = 1'b1;
  assign chain_index[0]        = entry_index;
  assign chain_value[0]        = entry_value;
  assign chain_min[0]          = {box_min_z, box_min_y, box_min_x};
  assign chain_max[0]          = {box_max_z, box_max_y, box_max_x};
  assign item_stall            = !chain_ready[0];

  for (genvar j = 0; j < N; j++) begin : g_cell
    if (j < N - 1) begin : g_mid
      afc_cell #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .AXIS       (j / 2),
        .NEG        (1'(j % 2))
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_ctrl   (chain_ctrl[j]),
        .in_index  (chain_index[j]),
        .in_value  (chain_value[j]),
        .in_min    (chain_min[j]),
        .in_max    (chain_max[j]),
        .in_ready  (chain_ready[j]),
        .out_ctrl  (chain_ctrl[j+1]),
        .out_index (chain_index[j+1]),
        .out_value (chain_value[j+1]),
        .out_min   (chain_min[j+1]),
        .out_max   (chain_max[j+1]),
        .out_ready (chain_ready[j+1])
      );
    end else begin : g_last
      afc_cell #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .AXIS       (j / 2),
        .NEG        (1'(j % 2))
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_ctrl   (chain_ctrl[j]),
        .in_index  (chain_index[j]),
        .in_value  (chain_value[j]),
        .in_min    (chain_min[j]),
        .in_max    (chain_max[j]),
        .in_ready  (chain_ready[j]),
        .out_ctrl  (chain_ctrl[j+1]),
        .out_index (),
        .out_value (),
        .out_min   (),
        .out_max   (),
        .out_ready (chain_ready[j+1])
      );
    end
  end

  assign last_ctrl = chain_ctrl[N];

  // write items are dropped here, tests need a free output slot
  assign chain_ready[N] = !last_ctrl.is_test || !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (last_ctrl.valid && last_ctrl.is_test && chain_ready[N]) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_ctrl.valid && last_ctrl.is_test && chain_ready[N]) begin
      inside_res <= last_ctrl.in_view;
    end
  end

  a_result_from_test: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(last_ctrl.valid && last_ctrl.is_test))
    else $error("result shown without a test item");

  a_write_drains: assert property (@(posedge clk) disable iff (rst)
    (last_ctrl.valid && !last_ctrl.is_test) |-> chain_ready[N])
    else $error("write item blocked at the output");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(inside_res)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
